// File: rtl/core/ctac_pkg.sv
// Package for the cell track associator.
// Holds result kinds, register indexes and the stored entry type.
// No dependencies.
`timescale 1ns / 1ps

package ctac_pkg;

    // Result kinds carried in each output beat.
    localparam logic [2:0] KIND_REJECTED  = 3'd0;
    localparam logic [2:0] KIND_CONTINUED = 3'd1;
    localparam logic [2:0] KIND_NEW       = 3'd2;
    localparam logic [2:0] KIND_DROPPED   = 3'd3;
    localparam logic [2:0] KIND_ENDED     = 3'd4;
    localparam logic [2:0] KIND_CLOSED    = 3'd5;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_GATE_X      = 3'd0;
    localparam logic [2:0] REG_GATE_Y      = 3'd1;
    localparam logic [2:0] REG_GATE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_WIDTH_MIN   = 3'd3;
    localparam logic [2:0] REG_WIDTH_MAX   = 3'd4;
    localparam logic [2:0] REG_HEIGHT_MIN  = 3'd5;
    localparam logic [2:0] REG_HEIGHT_MAX  = 3'd6;

    // One stored track entry.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] h;
        logic [15:0] id;
    } entry_t;

    // Entry as it travels around the ring, with its continuation mark.
    typedef struct packed {
        entry_t ent;
        logic   mark;
    } ring_t;

endpackage

// File: rtl/core/ctac_cell.sv
// One cell of the previous-frame ring: holds an entry and its mark.
// Loads from the current table at frame end, else takes its neighbor's entry on a shift.
// Depends on ctac_pkg.
`timescale 1ns / 1ps

module ctac_cell
    import ctac_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  entry_t load_ent,
    input  logic   shift,
    input  ring_t  from_next,
    output ring_t  value
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   mark_reg;
    logic   mark_next;

    // Load clears the mark; a shift takes the neighbor's entry.
    always_comb
    begin
        ent_next  = ent_reg;
        mark_next = mark_reg;
        if (load)
        begin
            ent_next  = load_ent;
            mark_next = 1'b0;
        end
        else if (shift)
        begin
            ent_next  = from_next.ent;
            mark_next = from_next.mark;
        end
    end

    // The mark is control state; the entry is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign value = '{ent: ent_reg, mark: mark_reg};

endmodule

// File: rtl/core/ctac_gate.sv
// Gate comparator at the head of the ring.
// Tests one stored entry against the detection on x, y and height.
// Depends on ctac_pkg.
`timescale 1ns / 1ps

module ctac_gate
    import ctac_pkg::*;
(
    input  entry_t      ent,
    input  logic [15:0] det_x,
    input  logic [15:0] det_y,
    input  logic [15:0] det_h,
    input  logic [15:0] gate_x,
    input  logic [15:0] gate_y,
    input  logic [15:0] gate_height,
    output logic        hit
);

    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dh;

    // Absolute differences, each strictly below its gate.
    always_comb
    begin
        dx  = (det_x >= ent.x) ? (det_x - ent.x) : (ent.x - det_x);
        dy  = (det_y >= ent.y) ? (det_y - ent.y) : (ent.y - det_y);
        dh  = (det_h >= ent.h) ? (det_h - ent.h) : (ent.h - det_h);
        hit = (dx < gate_x) && (dy < gate_y) && (dh < gate_height);
    end

endmodule

// File: rtl/core/cell_track_associator.sv
// Top level of the cell track associator.
// Uses ctac_pkg, ctac_cell (ring of previous-frame entries) and ctac_gate.
`timescale 1ns / 1ps

// Usage:
// Detections enter on the s_ stream: s_tdata carries center x/y and the two
// axes, s_tuser says whether the beat carries a detection, s_tlast marks the
// final beat of a frame. Results leave on the m_ stream as {track_id, kind},
// with m_tlast on the final result of an input beat.
// A detection that passes the size window and fits in the current table is
// gated by rotating the previous-frame ring once around its MAX_DETECTIONS
// cells, one cell per cycle, before its result beat is pushed. Frame end
// rotates the ring once more, one result beat per ended track, then one
// frame-closed beat.
// One input beat is worked at a time; s_tready is high only when idle.
// When the receiver stalls, the output register holds its beat and the ring
// stops at the next track that has to be reported.
// Reset empties both tables, clears the marks and the track ID counter and
// loads the default gates and size windows. The user must write the seven APB
// registers only while the block is idle; the block itself does not enforce it.
module cell_track_associator
    import ctac_pkg::*;
#(
    parameter int MAX_DETECTIONS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // center_x, center_y, axis_width, axis_height
    input  logic        s_tuser,   // has_detection
    input  logic        s_tlast,   // last_in_frame
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // kind[2:0], track_id[18:3], zero fill
    output logic        m_tlast,   // last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CW = $clog2(MAX_DETECTIONS + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DET    = 5'b00100,
        ST_CLOSE  = 5'b01000,
        ST_CLOSED = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] gate_x_reg, gate_y_reg, gate_h_reg;
    logic [15:0] wmin_reg, wmax_reg, hmin_reg, hmax_reg;
    logic        cfg_wr;

    // Latched input beat.
    logic [15:0] det_x_reg, det_y_reg, det_h_reg;
    logic        lif_reg, lif_next;
    logic [15:0] in_x, in_y, in_w, in_h;
    logic        size_ok;

    // Sequencing and track state.
    logic [IW-1:0] step_reg, step_next;
    logic [CW-1:0] prev_count_reg, prev_count_next;
    logic [CW-1:0] cur_count_reg, cur_count_next;
    logic [15:0]   last_id_reg, last_id_next;
    logic          found_reg, found_next;
    logic [15:0]   match_id_reg, match_id_next;
    logic [2:0]    det_kind_reg, det_kind_next;
    logic [15:0]   new_id;

    entry_t cur_entries_reg [MAX_DETECTIONS];
    logic   cur_wr;

    // Output register.
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [15:0] out_id_reg;
    logic        out_last_reg;
    logic        out_free;
    logic        push;
    logic [2:0]  push_kind;
    logic [15:0] push_id;
    logic        push_last;

    // Ring of previous-frame cells.
    ring_t ring_val [MAX_DETECTIONS];
    ring_t tail_in;
    logic  ring_shift;
    logic  ring_load;
    logic  head_hit;
    logic  in_range;
    logic  step_end;
    logic  emit_end;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_x_reg <= 16'd560;
            gate_y_reg <= 16'd112;
            gate_h_reg <= 16'd115;
            wmin_reg   <= 16'd272;
            wmax_reg   <= 16'd800;
            hmin_reg   <= 16'd480;
            hmax_reg   <= 16'd1536;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_GATE_X:      gate_x_reg <= pwdata[15:0];
                REG_GATE_Y:      gate_y_reg <= pwdata[15:0];
                REG_GATE_HEIGHT: gate_h_reg <= pwdata[15:0];
                REG_WIDTH_MIN:   wmin_reg   <= pwdata[15:0];
                REG_WIDTH_MAX:   wmax_reg   <= pwdata[15:0];
                REG_HEIGHT_MIN:  hmin_reg   <= pwdata[15:0];
                REG_HEIGHT_MAX:  hmax_reg   <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[4:2])
            REG_GATE_X:      prdata = {16'd0, gate_x_reg};
            REG_GATE_Y:      prdata = {16'd0, gate_y_reg};
            REG_GATE_HEIGHT: prdata = {16'd0, gate_h_reg};
            REG_WIDTH_MIN:   prdata = {16'd0, wmin_reg};
            REG_WIDTH_MAX:   prdata = {16'd0, wmax_reg};
            REG_HEIGHT_MIN:  prdata = {16'd0, hmin_reg};
            REG_HEIGHT_MAX:  prdata = {16'd0, hmax_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Ring cells; cell 0 is the head, its entry wraps to the last cell.
    for (genvar i = 0; i < MAX_DETECTIONS; i++)
    begin : g_ring
        ring_t from_next;
        if (i == MAX_DETECTIONS - 1)
        begin : g_tail
            assign from_next = tail_in;
        end
        else
        begin : g_mid
            assign from_next = ring_val[i + 1];
        end
        ctac_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (ring_load),
            .load_ent  (cur_entries_reg[i]),
            .shift     (ring_shift),
            .from_next (from_next),
            .value     (ring_val[i])
        );
    end

    ctac_gate u_gate (
        .ent         (ring_val[0].ent),
        .det_x       (det_x_reg),
        .det_y       (det_y_reg),
        .det_h       (det_h_reg),
        .gate_x      (gate_x_reg),
        .gate_y      (gate_y_reg),
        .gate_height (gate_h_reg),
        .hit         (head_hit)
    );

    // Head step bookkeeping.
    assign in_range = {{(CW - IW){1'b0}}, step_reg} < prev_count_reg;
    assign step_end = step_reg == IW'(MAX_DETECTIONS - 1);
    assign emit_end = (state_reg == ST_CLOSE) && in_range && !ring_val[0].mark;
    assign out_free = !out_valid_reg || m_tready;

    // The head entry wraps to the tail, marked if it continues the detection.
    always_comb
    begin
        tail_in      = ring_val[0];
        tail_in.mark = ring_val[0].mark ||
                       ((state_reg == ST_SCAN) && in_range && head_hit);
    end

    assign in_x    = s_tdata[15:0];
    assign in_y    = s_tdata[31:16];
    assign in_w    = s_tdata[47:32];
    assign in_h    = s_tdata[63:48];
    assign size_ok = (in_w > wmin_reg) && (in_w < wmax_reg) &&
                     (in_h > hmin_reg) && (in_h < hmax_reg);
    assign new_id  = (last_id_reg == 16'hFFFF) ? 16'd1 : (last_id_reg + 16'd1);
    assign s_tready = state_reg == ST_IDLE;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        lif_next        = lif_reg;
        found_next      = found_reg;
        match_id_next   = match_id_reg;
        det_kind_next   = det_kind_reg;
        prev_count_next = prev_count_reg;
        cur_count_next  = cur_count_reg;
        last_id_next    = last_id_reg;
        ring_shift      = 1'b0;
        ring_load       = 1'b0;
        cur_wr          = 1'b0;
        push            = 1'b0;
        push_kind       = KIND_CLOSED;
        push_id         = 16'd0;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lif_next   = s_tlast;
                    step_next  = '0;
                    found_next = 1'b0;
                    if (s_tuser)
                    begin
                        if (!size_ok)
                        begin
                            det_kind_next = KIND_REJECTED;
                            state_next    = ST_DET;
                        end
                        else if (cur_count_reg == CW'(MAX_DETECTIONS))
                        begin
                            det_kind_next = KIND_DROPPED;
                            state_next    = ST_DET;
                        end
                        else
                        begin
                            det_kind_next = KIND_NEW;
                            state_next    = ST_SCAN;
                        end
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_SCAN:
            begin
                ring_shift = 1'b1;
                step_next  = step_reg + 1'b1;
                if (in_range && head_hit)
                begin
                    found_next    = 1'b1;
                    match_id_next = ring_val[0].ent.id;
                    det_kind_next = KIND_CONTINUED;
                end
                if (step_end)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_kind = det_kind_reg;
                    push_last = !lif_reg;
                    step_next = '0;
                    if (det_kind_reg == KIND_CONTINUED)
                    begin
                        push_id = match_id_reg;
                    end
                    else if (det_kind_reg == KIND_NEW)
                    begin
                        push_id      = new_id;
                        last_id_next = new_id;
                    end
                    if (det_kind_reg == KIND_CONTINUED || det_kind_reg == KIND_NEW)
                    begin
                        cur_wr         = 1'b1;
                        cur_count_next = cur_count_reg + 1'b1;
                    end
                    state_next = lif_reg ? ST_CLOSE : ST_IDLE;
                end
            end
            ST_CLOSE:
            begin
                if (!emit_end || out_free)
                begin
                    ring_shift = 1'b1;
                    step_next  = step_reg + 1'b1;
                    if (emit_end)
                    begin
                        push      = 1'b1;
                        push_kind = KIND_ENDED;
                        push_id   = ring_val[0].ent.id;
                    end
                    if (step_end)
                    begin
                        state_next = ST_CLOSED;
                    end
                end
            end
            ST_CLOSED:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_kind       = KIND_CLOSED;
                    push_last       = 1'b1;
                    ring_load       = 1'b1;
                    prev_count_next = cur_count_reg;
                    cur_count_next  = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            lif_reg        <= 1'b0;
            found_reg      <= 1'b0;
            det_kind_reg   <= KIND_REJECTED;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            last_id_reg    <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            lif_reg        <= lif_next;
            found_reg      <= found_next;
            det_kind_reg   <= det_kind_next;
            prev_count_reg <= prev_count_next;
            cur_count_reg  <= cur_count_next;
            last_id_reg    <= last_id_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        match_id_reg <= match_id_next;
        if (s_tready && s_tvalid)
        begin
            det_x_reg <= in_x;
            det_y_reg <= in_y;
            det_h_reg <= in_h;
        end
        if (cur_wr)
        begin
            cur_entries_reg[cur_count_reg[IW-1:0]] <= '{x: det_x_reg, y: det_y_reg,
                                                       h: det_h_reg, id: push_id};
        end
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_id_reg   <= push_id;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_id_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    // Checks.
    a_cur_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_count_reg <= CW'(MAX_DETECTIONS))
        else $error("current table count beyond capacity");

    a_prev_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prev_count_reg <= CW'(MAX_DETECTIONS))
        else $error("previous table count beyond capacity");

    a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSED && out_free) |=> cur_count_reg == '0)
        else $error("frame close did not empty the current table");

    a_new_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_kind == KIND_NEW) |=> last_id_reg != 16'd0)
        else $error("track ID zero issued");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_CLOSE) |-> !s_tready)
        else $error("input accepted while the ring is rotating");

endmodule
